// File: design/kcl_pkg.sv
// Package for the keypad code lock: sizes, key and event codes, register
// indexes, the result word layout and the code digit helper.
// No dependencies.
package kcl_pkg;

    localparam int CODE_DIGITS = 4;
    localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int CODE_NIBS   = 4;

    localparam logic       OP_KEY  = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_CLEAR      = 4'd10;
    localparam logic [3:0] KEY_ENTER      = 4'd11;

    localparam logic [1:0] REG_SECRET_CODE = 2'd0;
    localparam logic [1:0] REG_UNLOCK_TICKS = 2'd1;
    localparam logic [1:0] REG_DENY_TICKS  = 2'd2;

    localparam logic [15:0] SECRET_CODE_RST = 16'h6754;
    localparam logic [15:0] UNLOCK_TICKS_RST = 16'd3000;
    localparam logic [15:0] DENY_TICKS_RST  = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GRANT  = 2'd1,
        EV_DENY   = 2'd2,
        EV_RELOCK = 2'd3
    } event_t;

    // packed MSB first: unlocked lands in bit 0
    typedef struct packed {
        logic             accepting_keys;
        logic [2:0]       digit_count;
        event_t           event_res;
        logic             unlocked;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // code digit i sits in nibble CODE_DIGITS-1-i; nibbles past the word read 0
    function automatic logic [3:0] code_digit(input logic [15:0] code, input int i);
        int nib;
        nib = CODE_DIGITS - 1 - i;
        if (nib >= CODE_NIBS || nib < 0) begin
            return 4'd0;
        end
        return code[4*nib +: 4];
    endfunction

endpackage

// File: design/keypad_code_lock.sv
// Keypad code lock top level: config registers, entry and timer state,
// per-word decision logic and an output register with a skid stage.
// Depends on kcl_pkg.
// Each accepted input word yields one registered result word.
// Throughput: one word per cycle while the skid stage is empty; the skid
// stage takes one word while m_tready is low, and s_tready is low while it is
// full. Reset (aresetn low, synchronous) clears the entry, locks the relay,
// zeroes both timers and loads the default code 6754, 3000 unlock ticks and 1000 hold ticks.
module keypad_code_lock (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [3:0] key_code, [7:4] zero
    input  logic                          s_tuser,   // [0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kcl_pkg::M_DATA_W-1:0]  m_tdata,   // [0] unlocked, [2:1] event_res,
                                                      // [5:3] digit_count,
                                                      // [6] accepting_keys, [7] zero
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);

    logic [15:0] secret_code_reg;
    logic [15:0] unlock_ticks_reg;
    logic [15:0] deny_ticks_reg;

    logic [3:0]                 digits_reg [kcl_pkg::CODE_DIGITS];
    logic [3:0]                 digits_next [kcl_pkg::CODE_DIGITS];
    logic [kcl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       unlock_reg, unlock_next;
    logic [15:0]                unlock_timer_reg, unlock_timer_next;
    logic [15:0]                deny_timer_reg, deny_timer_next;

    logic                       out_valid_reg, skid_valid_reg;
    kcl_pkg::result_t           out_data_reg, skid_data_reg;
    kcl_pkg::result_t           res;
    kcl_pkg::event_t            ev;
    logic                       accept;
    logic                       match;
    logic                       opcode;
    logic [3:0]                 key;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign opcode    = s_tuser;
    assign key       = s_tdata[3:0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = kcl_pkg::M_DATA_W'(out_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_code_reg  <= kcl_pkg::SECRET_CODE_RST;
            unlock_ticks_reg <= kcl_pkg::UNLOCK_TICKS_RST;
            deny_ticks_reg   <= kcl_pkg::DENY_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kcl_pkg::REG_SECRET_CODE:  secret_code_reg  <= cfg_data;
                kcl_pkg::REG_UNLOCK_TICKS: unlock_ticks_reg <= cfg_data;
                kcl_pkg::REG_DENY_TICKS:   deny_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        match = (count_reg == kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS));
        for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
            if (digits_reg[i] != kcl_pkg::code_digit(secret_code_reg, i)) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        digits_next       = digits_reg;
        count_next        = count_reg;
        unlock_next       = unlock_reg;
        unlock_timer_next = unlock_timer_reg;
        deny_timer_next   = deny_timer_reg;
        ev                = kcl_pkg::EV_NONE;
        if (accept) begin
            if (opcode == kcl_pkg::OP_TICK) begin
                if (deny_timer_reg != 16'd0) begin
                    deny_timer_next = deny_timer_reg - 16'd1;
                end
                if (unlock_reg) begin
                    if (unlock_timer_reg <= 16'd1) begin
                        unlock_timer_next = 16'd0;
                        unlock_next       = 1'b0;
                        ev                = kcl_pkg::EV_RELOCK;
                    end else begin
                        unlock_timer_next = unlock_timer_reg - 16'd1;
                    end
                end
            end else if (!unlock_reg && deny_timer_reg == 16'd0) begin
                if (key <= kcl_pkg::KEY_LAST_DIGIT) begin
                    if (count_reg < kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS)) begin
                        digits_next[count_reg[kcl_pkg::IDX_W-1:0]] = key;
                        count_next = count_reg + kcl_pkg::CNT_W'(1);
                    end
                end else if (key == kcl_pkg::KEY_CLEAR) begin
                    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
                        digits_next[i] = 4'd0;
                    end
                    count_next = '0;
                end else if (key == kcl_pkg::KEY_ENTER) begin
                    if (match) begin
                        unlock_next       = 1'b1;
                        unlock_timer_next = unlock_ticks_reg;
                        ev                = kcl_pkg::EV_GRANT;
                    end else begin
                        deny_timer_next = deny_ticks_reg;
                        ev              = kcl_pkg::EV_DENY;
                    end
                    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
                        digits_next[i] = 4'd0;
                    end
                    count_next = '0;
                end
            end
        end
        res.unlocked       = unlock_next;
        res.event_res      = ev;
        res.digit_count    = 3'(count_next);
        res.accepting_keys = !unlock_next && (deny_timer_next == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
                digits_reg[i] <= 4'd0;
            end
            count_reg        <= '0;
            unlock_reg       <= 1'b0;
            unlock_timer_reg <= 16'd0;
            deny_timer_reg   <= 16'd0;
        end else begin
            digits_reg       <= digits_next;
            count_reg        <= count_next;
            unlock_reg       <= unlock_next;
            unlock_timer_reg <= unlock_timer_next;
            deny_timer_reg   <= deny_timer_next;
        end
    end

    // output register plus skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept) begin
                out_data_reg <= res;
            end
        end else if (accept) begin
            skid_data_reg <= res;
        end
    end

endmodule

// File: design/kcl_checker.sv
// Port-level checker for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock.
module kcl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kcl_pkg::M_DATA_W-1:0]  m_tdata
);

    logic       unlocked;
    logic [1:0] ev;
    logic [2:0] cnt;
    logic       accepting;

    assign unlocked  = m_tdata[0];
    assign ev        = m_tdata[2:1];
    assign cnt       = m_tdata[5:3];
    assign accepting = m_tdata[6];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_unlock_blocks_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && unlocked |-> !accepting)
        else $error("keys accepted while unlocked");

    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ev == kcl_pkg::EV_GRANT |-> unlocked && cnt == 3'd0)
        else $error("grant without unlock or with entry left");

    a_deny_relock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ev == kcl_pkg::EV_DENY || ev == kcl_pkg::EV_RELOCK) |-> !unlocked)
        else $error("deny or relock left the lock open");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/keypad_code_lock_checker.sv
// Checker for the keypad code lock: follows the config, input and result channels,
// keeps its own copy of the lock state and compares every result word with its prediction.
// Depends on kcl_pkg.
module keypad_code_lock_checker
    import kcl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_words
);

    logic [15:0]      code_reg;
    logic [15:0]      open_ticks_reg;
    logic [15:0]      hold_ticks_reg;
    logic [3:0]       digits [CODE_DIGITS];
    logic [CNT_W-1:0] count;
    logic             is_open;
    logic [15:0]      open_timer;
    logic [15:0]      hold_timer;
    result_t          lock_status_q[$];
    int               errors = 0;

    function automatic void clear_entry();
        foreach (digits[i]) begin
            digits[i] = 4'd0;
        end
        count = '0;
    endfunction

    function automatic logic code_matches();
        int         i;
        int         nib;
        logic [3:0] want;
        if (count != CODE_DIGITS) begin
            return 1'b0;
        end
        for (i = 0; i < CODE_DIGITS; i++) begin
            nib  = CODE_DIGITS - 1 - i;
            want = (nib < 4) ? code_reg[4*nib +: 4] : 4'd0;
            if (digits[i] != want) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic step_lock(input logic op, input logic [3:0] key);
        result_t status;
        event_t  ev;
        ev = EV_NONE;
        if (op == OP_TICK) begin
            if (hold_timer != 16'd0) begin
                hold_timer--;
            end
            if (is_open) begin
                if (open_timer <= 16'd1) begin
                    open_timer = 16'd0;
                    is_open    = 1'b0;
                    ev         = EV_RELOCK;
                end else begin
                    open_timer--;
                end
            end
        end else if (!is_open && hold_timer == 16'd0) begin
            if (key <= KEY_LAST_DIGIT) begin
                if (count < CODE_DIGITS) begin
                    digits[count[IDX_W-1:0]] = key;
                    count++;
                end
            end else if (key == KEY_CLEAR) begin
                clear_entry();
            end else if (key == KEY_ENTER) begin
                if (code_matches()) begin
                    is_open    = 1'b1;
                    open_timer = open_ticks_reg;
                    ev         = EV_GRANT;
                end else begin
                    hold_timer = hold_ticks_reg;
                    ev         = EV_DENY;
                end
                clear_entry();
            end
        end
        status.unlocked       = is_open;
        status.event_res      = ev;
        status.digit_count    = 3'(count);
        status.accepting_keys = !is_open && hold_timer == 16'd0;
        lock_status_q.push_back(status);
    endtask

    task automatic compare_field(input string what, input logic [3:0] want,
                                 input logic [3:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            code_reg       = SECRET_CODE_RST;
            open_ticks_reg = UNLOCK_TICKS_RST;
            hold_ticks_reg = DENY_TICKS_RST;
            clear_entry();
            is_open    = 1'b0;
            open_timer = 16'd0;
            hold_timer = 16'd0;
            lock_status_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SECRET_CODE:  code_reg = cfg_data;
                    REG_UNLOCK_TICKS: open_ticks_reg = cfg_data;
                    REG_DENY_TICKS:   hold_ticks_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (lock_status_q.size() == 0) begin
                    $display("%0t: result word expected none, got %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = lock_status_q.pop_front();
                    compare_field("unlocked", want.unlocked, got.unlocked);
                    compare_field("event_res", want.event_res, got.event_res);
                    compare_field("digit_count", want.digit_count, got.digit_count);
                    compare_field("accepting_keys", want.accepting_keys,
                                  got.accepting_keys);
                end
            end
            if (s_tvalid && s_tready) begin
                step_lock(s_tuser, s_tdata[3:0]);
            end
        end
        fail_count    <= errors;
        pending_words <= lock_status_q.size();
    end

endmodule

// File: tb/sv/keypad_code_lock_test.sv
// Top of the keypad code lock testbench: clock, reset, key and tick stimulus, config
// writes and the final verdict. Depends on kcl_pkg, keypad_code_lock and the checker.
module keypad_code_lock_test;
    import kcl_pkg::*;

    localparam logic [1:0] REG_SPARE       = 2'd3;
    localparam int         PHASES          = 8;
    localparam int         WORDS_PER_PHASE = 250;

    logic                aclk     = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;
    int                  fail_count;
    int                  pending_words;

    int          burst_left = 0;
    bit          no_gaps    = 1'b0;
    int          sent_words = 0;
    logic [15:0] code_now;
    bit          ready_low  = 1'b0;
    int          ready_hold = 0;

    always #5 aclk = ~aclk;

    keypad_code_lock dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    keypad_code_lock_checker lock_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_words(pending_words)
    );

    // receiver: short stalls, ready stretches of mixed length
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            ready_low  = !ready_low;
            ready_hold = ready_low ? $urandom_range(0, 3) :
                         ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(0, 8);
        end
        m_tready <= !ready_low;
    end

    task automatic send_word(input logic op, input logic [3:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && !no_gaps) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, key};
        do @(posedge aclk); while (!s_tready);
        sent_words++;
    endtask

    task automatic key_in_code(input logic [15:0] code);
        int i;
        for (i = 0; i < CODE_DIGITS; i++) begin
            send_word(OP_KEY, code[4*(CODE_DIGITS-1-i) +: 4]);
        end
        send_word(OP_KEY, KEY_ENTER);
    endtask

    task automatic wrong_entry();
        repeat ($urandom_range(0, CODE_DIGITS + 1)) send_word(OP_KEY, 4'($urandom_range(0, 9)));
        send_word(OP_KEY, KEY_ENTER);
    endtask

    // only called with the input channel idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SECRET_CODE: code_now = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_words != 0);
        repeat (2) @(posedge aclk);
    endtask

    function automatic logic [15:0] decimal_code();
        logic [15:0] code;
        int          i;
        for (i = 0; i < 4; i++) begin
            code[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return code;
    endfunction

    initial begin
        int phase;
        int pick;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= OP_KEY;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SECRET_CODE;
        cfg_data  <= 16'd0;
        code_now  = SECRET_CODE_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default code: full entry, extra digit, unused code, clear, grant, key while open, relock
        write_reg(REG_UNLOCK_TICKS, 16'd2);
        send_word(OP_KEY, 4'd6);
        send_word(OP_KEY, 4'd7);
        send_word(OP_KEY, 4'd5);
        send_word(OP_KEY, 4'd4);
        send_word(OP_KEY, 4'd9);
        send_word(OP_KEY, 4'd15);
        send_word(OP_KEY, KEY_CLEAR);
        key_in_code(SECRET_CODE_RST);
        send_word(OP_KEY, 4'd3);
        send_word(OP_TICK, 4'd0);
        send_word(OP_TICK, 4'd0);
        wait_idle();

        // zero unlock ticks, no hold, all-nines code, spare register index
        write_reg(REG_UNLOCK_TICKS, 16'd0);
        write_reg(REG_DENY_TICKS, 16'd0);
        write_reg(REG_SECRET_CODE, 16'h9999);
        write_reg(REG_SPARE, 16'hFFFF);
        send_word(OP_KEY, KEY_ENTER);
        key_in_code(16'h9999);
        send_word(OP_TICK, 4'd15);
        send_word(OP_KEY, 4'd12);
        wait_idle();

        // code with non-decimal nibbles never matches; short hold
        write_reg(REG_SECRET_CODE, 16'h5AB3);
        write_reg(REG_DENY_TICKS, 16'd2);
        write_reg(REG_UNLOCK_TICKS, 16'd1);
        key_in_code(16'h5003);
        send_word(OP_KEY, 4'd1);
        send_word(OP_TICK, 4'd7);
        send_word(OP_TICK, 4'd8);
        wait_idle();

        sent_words = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                write_reg(REG_SECRET_CODE, 16'h0000);
            end else if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SECRET_CODE, 16'($urandom_range(0, 39321)));
            end else begin
                write_reg(REG_SECRET_CODE, decimal_code());
            end
            write_reg(REG_UNLOCK_TICKS, 16'($urandom_range(0, 24)));
            write_reg(REG_DENY_TICKS, 16'($urandom_range(0, 16)));
            while (sent_words < (phase + 1) * WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_word(OP_KEY, KEY_CLEAR);
                    end
                    key_in_code(code_now);
                end else if (pick < 50) begin
                    wrong_entry();
                end else if (pick < 82) begin
                    repeat ($urandom_range(1, 12)) send_word(OP_TICK, 4'($urandom_range(0, 15)));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                    end
                end
            end
            wait_idle();
        end

        // run out both timers and empty the entry
        repeat (40) send_word(OP_TICK, 4'd0);
        send_word(OP_KEY, KEY_CLEAR);
        wait_idle();

        // long unlock: relock only on the very last tick
        write_reg(REG_UNLOCK_TICKS, 16'd100);
        write_reg(REG_DENY_TICKS, 16'd0);
        write_reg(REG_SECRET_CODE, decimal_code());
        key_in_code(code_now);
        no_gaps = 1'b1;
        repeat (100) send_word(OP_TICK, 4'($urandom_range(0, 15)));
        no_gaps = 1'b0;
        send_word(OP_KEY, 4'd5);
        wait_idle();

        // longest hold: every key after the denial is ignored
        write_reg(REG_DENY_TICKS, 16'hFFFF);
        send_word(OP_KEY, KEY_ENTER);
        repeat (20) send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        wait_idle();

        if (fail_count == 0 && pending_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
